// File: hdl/ifam_pkg.sv
// ----------------------------------------------------------------------------
// ifam_pkg
// Shared types and constants of the intercom frame alarm matcher.
// ----------------------------------------------------------------------------
package ifam_pkg;

  localparam int unsigned FRAME_LEN = 18;
  localparam int unsigned COUNT_MAX = 19;
  localparam int unsigned MAX_ENTRIES = 8;

  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_ETX = 8'h03;
  localparam logic [7:0] CHAR_F = 8'h46;
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_1 = 8'h31;
  localparam logic [7:0] CHAR_2 = 8'h32;
  localparam logic [7:0] CHAR_4 = 8'h34;

  // Positions of the checked characters within a frame.
  localparam int unsigned POS_TASK_HI = 2;
  localparam int unsigned POS_TASK_LO = 3;
  localparam int unsigned POS_NUM_X = 6;
  localparam int unsigned POS_NUM_Y = 10;
  localparam int unsigned POS_TYPE_HI = 14;
  localparam int unsigned POS_TYPE_LO = 15;

  // Table entry layout.
  localparam int unsigned ENTRY_W = 52;

  typedef struct packed {
    logic        valid;
    logic [2:0]  len;
    logic [31:0] digits;
    logic [15:0] alarm_number;
  } entry_t;

  // Result beat, last field in the lowest bits.
  typedef struct packed {
    logic [6:0]  pad;
    logic [2:0]  subscriber_length;
    logic [31:0] subscriber_digits;
    logic [2:0]  matched_entry;
    logic        alarm_on;
    logic [15:0] alarm_number;
    logic        alarm_event;
    logic        length_error;
  } result_t;

  // Mask that keeps the first len characters of a four-character word.
  function automatic logic [31:0] char_mask(logic [2:0] len);
    logic [31:0] m;
    m = '0;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < len) begin
        m[31 - 8 * k -: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// File: hdl/intercom_frame_alarm_matcher.sv
// ----------------------------------------------------------------------------
// intercom_frame_alarm_matcher
// Collects intercom frames from a byte stream and matches call messages
// against a small subscriber table.
// ----------------------------------------------------------------------------
// Usage:
// Received serial bytes arrive as beats on the s_axis channel, one byte per
// beat. STX empties the frame, ETX closes it and produces exactly one result
// beat on the m_axis channel (which also stands for the ACK); every other
// byte is appended to the frame. Frames that are not 18 characters long
// report a length error. Call start and call end messages of task "42" have
// their two subscriber numbers stripped up to the last 'F' and compared with
// the valid entries of the table; the first matching entry raises the event.
// The table is written through the APB port, eight 52-bit entries at byte
// addresses 8*i; reads return the stored entry.
// Timing: an accepted byte is held in the input register, where the frame
// is updated and an ETX is evaluated; once the ETX moves on, the result beat
// is presented from the result register in the following cycle.
// Throughput: one beat per cycle while no ETX waits, set by the single input
// register stage. When the receiver stalls, data bytes are still taken; an
// ETX waits in the input register until the result register is free.
// Reset clears the character count, the table and both valid flags.
// ----------------------------------------------------------------------------
module intercom_frame_alarm_matcher #(
  parameter int unsigned TABLE_ENTRIES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // Result stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] length_error, [1] alarm_event, [17:2] alarm_number, [18] alarm_on,
  // [21:19] matched_entry, [53:22] subscriber_digits,
  // [56:54] subscriber_length, [63:57] zero
  output logic [63:0] m_axis_tdata,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import ifam_pkg::*;

  // Subscriber table.
  entry_t entry_q [MAX_ENTRIES];

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // Frame state.
  logic [7:0] frame_q [FRAME_LEN];
  logic [4:0] count_q, count_d;

  // Result register.
  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;

  logic is_stx, is_etx, advance, out_free;

  assign pready = 1'b1;
  assign prdata = {12'd0, entry_q[paddr[5:3]]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        entry_q[i] <= '0;
      end
    end else if (psel && penable && pwrite) begin
      entry_q[paddr[5:3]] <= entry_t'(pwdata[ENTRY_W-1:0]);
    end
  end

  assign is_stx   = (in_byte_q == BYTE_STX);
  assign is_etx   = (in_byte_q == BYTE_ETX);
  assign out_free = !out_valid_q || m_axis_tready;
  // Data bytes never need the result register; an ETX does.
  assign advance  = in_valid_q && (!is_etx || out_free);

  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  // Character count and frame buffer.
  always_comb begin
    count_d = count_q;
    if (advance) begin
      if (is_stx) begin
        count_d = '0;
      end else if (!is_etx && count_q < 5'(COUNT_MAX)) begin
        count_d = count_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && !is_stx && !is_etx && count_q < 5'(FRAME_LEN)) begin
      frame_q[count_q] <= in_byte_q;
    end
  end

  // Frame evaluation.
  logic        is_call, call_on;
  logic [31:0] num_x, num_y, strip_x, strip_y;
  logic [2:0]  len_x, len_y;
  logic [2:0]  first_x, first_y;

  assign num_x = {frame_q[POS_NUM_X], frame_q[POS_NUM_X+1],
                  frame_q[POS_NUM_X+2], frame_q[POS_NUM_X+3]};
  assign num_y = {frame_q[POS_NUM_Y], frame_q[POS_NUM_Y+1],
                  frame_q[POS_NUM_Y+2], frame_q[POS_NUM_Y+3]};

  assign is_call = (frame_q[POS_TASK_HI] == CHAR_4) && (frame_q[POS_TASK_LO] == CHAR_2) &&
                   (frame_q[POS_TYPE_HI] == CHAR_1) &&
                   ((frame_q[POS_TYPE_LO] == CHAR_2) || (frame_q[POS_TYPE_LO] == CHAR_0));
  assign call_on = (frame_q[POS_TYPE_LO] == CHAR_2);

  // The number keeps the characters after its last 'F', left aligned.
  always_comb begin
    first_x = '0;
    first_y = '0;
    for (int k = 0; k < 4; k++) begin
      if (num_x[31 - 8 * k -: 8] == CHAR_F) first_x = 3'(k + 1);
      if (num_y[31 - 8 * k -: 8] == CHAR_F) first_y = 3'(k + 1);
    end
    len_x   = 3'd4 - first_x;
    len_y   = 3'd4 - first_y;
    strip_x = num_x << {first_x, 3'b000};
    strip_y = num_y << {first_y, 3'b000};
  end

  logic       found;
  logic [2:0] hit_idx;

  always_comb begin
    logic hx, hy;
    found   = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hx = (entry_q[i].len == len_x) &&
           (((entry_q[i].digits ^ strip_x) & char_mask(len_x)) == '0);
      hy = (entry_q[i].len == len_y) &&
           (((entry_q[i].digits ^ strip_y) & char_mask(len_y)) == '0);
      if (!found && entry_q[i].valid && (hx || hy)) begin
        found   = 1'b1;
        hit_idx = 3'(i);
      end
    end
  end

  always_comb begin
    out_d = '0;
    if (count_q != 5'(FRAME_LEN)) begin
      out_d.length_error = 1'b1;
    end else if (is_call && found) begin
      out_d.alarm_event   = 1'b1;
      out_d.alarm_number  = entry_q[hit_idx].alarm_number;
      out_d.alarm_on      = call_on;
      out_d.matched_entry = hit_idx;
      if (call_on) begin
        out_d.subscriber_digits = entry_q[hit_idx].digits & char_mask(entry_q[hit_idx].len);
        out_d.subscriber_length = entry_q[hit_idx].len;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    if (advance && is_etx) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_etx) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // Assertions
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 5'(COUNT_MAX))
    else $error("character count beyond saturation");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && s_axis_tready) |-> advance)
    else $error("input register overwritten before it moved on");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_q)))
    else $error("pending result lost or changed under stall");

  a_event_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.alarm_event && out_q.length_error) &&
                    (out_q.subscriber_length == 3'd0 || out_q.alarm_on))
    else $error("inconsistent result fields");

endmodule

// File: bench/intercom_frame_alarm_matcher_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// intercom_frame_alarm_matcher_tb
// Self-checking bench for the intercom frame alarm matcher. Byte beats are
// sent from a queue and every result beat is checked against a frame tracker
// kept alongside the block. The tracker follows STX, ETX and the character
// count, and matches call messages against a copy of the subscriber table.
// The table is rewritten over APB between phases with random, directed and
// extreme contents. Random call frames are built mostly from table strings,
// so that alarm events occur often.
// ----------------------------------------------------------------------------
module intercom_frame_alarm_matcher_tb;
  import ifam_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 8;
  // Cycles without any accepted beat before the run is abandoned. The
  // longest honest quiet stretch is a table rewrite.
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned ITEMS_PER_PHASE = 470;

  typedef enum int unsigned {TBL_DIRECTED, TBL_RANDOM, TBL_EXTREME} tbl_mode_e;

  typedef struct {
    logic [7:0] data;
    bit         hold;  // wait until every pending result has come back
  } rx_beat_t;

  typedef logic [7:0] frame_t [FRAME_LEN];

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [0] length_error, [1] alarm_event, [17:2] alarm_number, [18] alarm_on,
  // [21:19] matched_entry, [53:22] subscriber_digits,
  // [56:54] subscriber_length, [63:57] zero
  logic [63:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  // Beats waiting to be sent and results waiting to be seen.
  rx_beat_t    rx_beat_q [$];
  result_t     alarm_queue [$];
  int unsigned beats_queued = 0;
  bit          hold_next = 1'b0;

  // Tracker state: a mirror of the frame store, the count and the table.
  logic [7:0]  frame_buf [FRAME_LEN];
  logic [4:0]  char_cnt = '0;
  entry_t      table_shadow [MAX_ENTRIES] = '{default: '0};
  frame_t      draft;

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_idle_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned error_count = 0;

  intercom_frame_alarm_matcher #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Frame tracker
  // --------------------------------------------------------------------------

  // Keeps the characters of a four-character number that follow its last F,
  // first kept character in the top byte.
  function automatic void strip_number(input int unsigned pos, output logic [31:0] num,
                                       output int unsigned len);
    int unsigned start;
    start = 0;
    for (int i = 0; i < 4; i++) begin
      if (frame_buf[pos + i] == CHAR_F) start = i + 1;
    end
    num = '0;
    len = 0;
    for (int i = start; i < 4; i++) begin
      num[31 - 8 * len -: 8] = frame_buf[pos + i];
      len++;
    end
  endfunction

  // An entry matches when its length equals the number's and its leading
  // characters agree; characters beyond the length play no part.
  function automatic bit number_hits(input entry_t e, input logic [31:0] num,
                                     input int unsigned len);
    if (e.len != len) return 1'b0;
    for (int k = 0; k < len; k++) begin
      if (e.digits[31 - 8 * k -: 8] != num[31 - 8 * k -: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advances the tracker by one received byte; returns 1 when the byte is an
  // ETX, which always yields exactly one result beat.
  function automatic bit frame_result(input logic [7:0] rx, output result_t res);
    logic [31:0] num_x, num_y;
    int unsigned len_x, len_y;
    bit          call_on;
    entry_t      e;
    res = '0;
    if (rx == BYTE_STX) begin
      char_cnt = '0;
      return 1'b0;
    end
    if (rx != BYTE_ETX) begin
      // Characters beyond the eighteenth are counted but not stored.
      if (char_cnt < FRAME_LEN) frame_buf[char_cnt] = rx;
      if (char_cnt < COUNT_MAX) char_cnt++;
      return 1'b0;
    end
    // ETX leaves the frame as it is, so a second ETX checks it again.
    if (char_cnt != FRAME_LEN) begin
      res.length_error = 1'b1;
      return 1'b1;
    end
    if (frame_buf[POS_TASK_HI] == CHAR_4 && frame_buf[POS_TASK_LO] == CHAR_2 &&
        frame_buf[POS_TYPE_HI] == CHAR_1 &&
        (frame_buf[POS_TYPE_LO] == CHAR_2 || frame_buf[POS_TYPE_LO] == CHAR_0)) begin
      call_on = (frame_buf[POS_TYPE_LO] == CHAR_2);
      strip_number(POS_NUM_X, num_x, len_x);
      strip_number(POS_NUM_Y, num_y, len_y);
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        e = table_shadow[i];
        if (e.valid && (number_hits(e, num_x, len_x) || number_hits(e, num_y, len_y))) begin
          res.alarm_event = 1'b1;
          res.alarm_number = e.alarm_number;
          res.alarm_on = call_on;
          res.matched_entry = 3'(i);
          // The subscriber string is only reported when the alarm goes on.
          if (call_on) begin
            res.subscriber_length = e.len;
            for (int k = 0; k < e.len; k++) begin
              res.subscriber_digits[31 - 8 * k -: 8] = e.digits[31 - 8 * k -: 8];
            end
          end
          break;
        end
      end
    end
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic void push_beat(input logic [7:0] data);
    rx_beat_t b;
    b.data = data;
    b.hold = hold_next;
    hold_next = 1'b0;
    rx_beat_q.push_back(b);
    beats_queued++;
  endfunction

  // Any byte that is neither STX nor ETX.
  function automatic logic [7:0] any_char();
    logic [7:0] r;
    do begin
      r = 8'($urandom);
    end while (r == BYTE_STX || r == BYTE_ETX);
    return r;
  endfunction

  // Characters that favour digits and F, which matter most to the stripping.
  function automatic logic [7:0] num_char();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) return 8'($urandom_range(8'h39, 8'h30));
    if (pick < 70) return CHAR_F;
    return any_char();
  endfunction

  // Fills one subscriber number of the draft; more often than not it is a
  // table string behind a run of padding that ends in F.
  function automatic void put_number(input int unsigned pos);
    entry_t      e;
    int unsigned str_len;
    for (int k = 0; k < 4; k++) draft[pos + k] = num_char();
    if ($urandom_range(99) < 60) begin
      e = table_shadow[$urandom_range(MAX_ENTRIES - 1)];
      if (e.len <= 4) begin
        str_len = e.len;
        for (int k = 0; k < str_len; k++) begin
          draft[pos + 4 - str_len + k] = e.digits[31 - 8 * k -: 8];
        end
        if (str_len < 4) draft[pos + 3 - str_len] = CHAR_F;
      end
    end
  endfunction

  // Builds an eighteen-character frame; a call message has task 42, type 12
  // or 10, and now and then one of those header characters spoilt.
  function automatic void fill_frame(input bit call);
    for (int i = 0; i < FRAME_LEN; i++) draft[i] = any_char();
    if (call) begin
      draft[POS_TASK_HI] = CHAR_4;
      draft[POS_TASK_LO] = CHAR_2;
      draft[POS_TYPE_HI] = CHAR_1;
      draft[POS_TYPE_LO] = $urandom_range(1) ? CHAR_2 : CHAR_0;
      put_number(POS_NUM_X);
      put_number(POS_NUM_Y);
      if ($urandom_range(99) < 15) begin
        case ($urandom_range(3))
          0: draft[POS_TASK_HI] = num_char();
          1: draft[POS_TASK_LO] = num_char();
          2: draft[POS_TYPE_HI] = num_char();
          default: draft[POS_TYPE_LO] = num_char();
        endcase
      end
    end
  endfunction

  function automatic void push_frame();
    push_beat(BYTE_STX);
    for (int i = 0; i < FRAME_LEN; i++) push_beat(draft[i]);
    push_beat(BYTE_ETX);
  endfunction

  // Mostly well-formed frames, with wrong lengths, ETX without STX and raw
  // noise mixed in.
  task automatic queue_random(input int unsigned n_items);
    int unsigned start_count, run_idx, pick;
    start_count = beats_queued;
    run_idx = 0;
    while (beats_queued - start_count < n_items) begin
      // One early run per phase holds back until all results are in.
      hold_next = (run_idx == 10) || ($urandom_range(99) < 3);
      pick = $urandom_range(99);
      if (pick < 65) begin
        fill_frame(1'b1);
        push_frame();
      end else if (pick < 72) begin
        fill_frame(1'b0);
        push_frame();
      end else if (pick < 82) begin
        push_beat(BYTE_STX);
        repeat ($urandom_range(24)) push_beat(any_char());
        push_beat(BYTE_ETX);
      end else if (pick < 90) begin
        repeat ($urandom_range(3)) push_beat(any_char());
        push_beat(BYTE_ETX);
      end else begin
        repeat ($urandom_range(6, 1)) push_beat(8'($urandom));
      end
      run_idx++;
    end
  endtask

  // Writes all eight entries; shadow copies are updated as each write lands.
  task automatic load_table(input tbl_mode_e mode);
    entry_t e;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      e.valid = ($urandom_range(99) < 85);
      e.len = ($urandom_range(99) < 85) ? 3'($urandom_range(4)) : 3'($urandom_range(7, 5));
      for (int k = 0; k < 4; k++) begin
        e.digits[31 - 8 * k -: 8] = ($urandom_range(99) < 80) ?
                                    8'($urandom_range(8'h39, 8'h30)) : 8'($urandom);
      end
      e.alarm_number = 16'($urandom);
      if (mode == TBL_DIRECTED) begin
        // An invalid entry and an overlong one lie ahead of the real match.
        case (i)
          0: e = '{valid: 1'b0, len: 3'd3, digits: "789Z", alarm_number: 16'h1111};
          1: e = '{valid: 1'b1, len: 3'd5, digits: "7890", alarm_number: 16'h2222};
          2: e = '{valid: 1'b1, len: 3'd3, digits: "789Z", alarm_number: 16'hA5C3};
          default: ;
        endcase
      end else if (mode == TBL_EXTREME) begin
        case (i)
          0: e = '1;
          1: e = '0;
          2: begin
            e.valid = 1'b1;
            e.len = 3'd4;
            e.alarm_number = '0;
          end
          // A twin of entry 3 that can never win against it.
          6: begin
            e = table_shadow[3];
            e.alarm_number = ~e.alarm_number;
          end
          // The empty string, matched by any number that ends in F.
          7: begin
            e.valid = 1'b1;
            e.len = 3'd0;
            e.digits = '1;
            e.alarm_number = '1;
          end
          default: ;
        endcase
      end
      @(posedge clk_i);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 6'(8 * i);
      pwdata <= {12'h000, e};
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      table_shadow[i] = e;
    end
  endtask

  // Waits until every beat is sent and every result seen, looking between
  // clock edges so that the driver's updates have settled, then lets a byte
  // still in the input register move on before the table is touched.
  task automatic wait_for_quiet();
    while (rx_beat_q.size() != 0 || s_axis_tvalid || alarm_queue.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents queued byte beats, idling at random. A beat marked hold
  // is not presented while results are still outstanding.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : byte_driver
    bit      present_next;
    result_t res;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (frame_result(s_axis_tdata, res)) alarm_queue.push_back(res);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        present_next = (rx_beat_q.size() != 0) && ($urandom_range(99) >= sender_idle_pct);
        if (present_next && rx_beat_q[0].hold && alarm_queue.size() != 0) begin
          present_next = 1'b0;
        end
        if (present_next) begin
          s_axis_tdata <= rx_beat_q[0].data;
          void'(rx_beat_q.pop_front());
        end
        s_axis_tvalid <= present_next;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: stalls the result channel at random and checks every accepted
  // result beat against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_monitor
    result_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata);
        if (alarm_queue.size() == 0) begin
          error_count++;
          $display("%0t: result beat %h arrived with none expected", $time, m_axis_tdata);
        end else begin
          want = alarm_queue.pop_front();
          check_field("length_error", 32'(want.length_error), 32'(got.length_error));
          check_field("alarm_event", 32'(want.alarm_event), 32'(got.alarm_event));
          check_field("alarm_number", 32'(want.alarm_number), 32'(got.alarm_number));
          check_field("alarm_on", 32'(want.alarm_on), 32'(got.alarm_on));
          check_field("matched_entry", 32'(want.matched_entry), 32'(got.matched_entry));
          check_field("subscriber_digits", want.subscriber_digits, got.subscriber_digits);
          check_field("subscriber_length", 32'(want.subscriber_length),
                      32'(got.subscriber_length));
          check_field("padding", 32'(want.pad), 32'(got.pad));
        end
      end
      m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Watchdog: ends the run when no beat has been accepted for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    sender_idle_pct <= 19;
    receiver_idle_pct <= 54;
    @(posedge clk_i);

    // Directed part: a call start whose first number strips to "789" and
    // finds entry 2, with the lowest and highest byte values in the filler.
    load_table(TBL_DIRECTED);
    fill_frame(1'b1);
    draft[0] = 8'h00;
    draft[1] = 8'hFF;
    draft[POS_TASK_HI] = CHAR_4;
    draft[POS_TASK_LO] = CHAR_2;
    draft[POS_TYPE_HI] = CHAR_1;
    draft[POS_TYPE_LO] = CHAR_2;
    {draft[POS_NUM_X], draft[POS_NUM_X + 1], draft[POS_NUM_X + 2], draft[POS_NUM_X + 3]} = "F789";
    {draft[POS_NUM_Y], draft[POS_NUM_Y + 1], draft[POS_NUM_Y + 2], draft[POS_NUM_Y + 3]} = "1111";
    push_frame();
    // A second ETX without STX checks the same frame once more.
    hold_next = 1'b1;
    push_beat(BYTE_ETX);
    // Further bytes overfill the frame, so the next ETX is a length error.
    push_beat(8'hFF);
    push_beat(8'h00);
    push_beat(BYTE_ETX);
    // An empty frame.
    push_beat(BYTE_STX);
    push_beat(BYTE_ETX);
    wait_for_quiet();

    load_table(TBL_RANDOM);
    queue_random(ITEMS_PER_PHASE);
    wait_for_quiet();

    // Second phase: the sender idles often, the receiver stalls little.
    sender_idle_pct <= 54;
    receiver_idle_pct <= 19;
    load_table(TBL_EXTREME);
    queue_random(ITEMS_PER_PHASE);
    wait_for_quiet();

    // Last phase at full rate on both sides.
    sender_idle_pct <= 0;
    receiver_idle_pct <= 0;
    load_table(TBL_RANDOM);
    queue_random(ITEMS_PER_PHASE);
    wait_for_quiet();

    repeat (8) @(posedge clk_i);
    if (error_count == 0 && alarm_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
